/* rtl/tafs_pkg.sv */
// Shared types, widths and the cosine boundary table for the angle unit.
package tafs_pkg;

	localparam int SIDE_W     = 16;
	localparam int COS_F      = 24;
	localparam int NUM_BOUNDS = 180;
	localparam int IDX_W      = 8;
	localparam int SQ_W       = 2 * SIDE_W;
	localparam int NUM_W      = 2 * SIDE_W + 3;
	localparam int DEN_W      = 2 * SIDE_W + 1;
	localparam int COS_W      = COS_F + 2;
	localparam int CMP_W      = NUM_W + COS_F + 2;
	localparam int ANG_W      = 8;
	localparam logic [ANG_W-1:0] ANGLE_MAX = ANG_W'(NUM_BOUNDS);

	typedef enum logic [1:0] {
		CLS_NORMAL = 2'd0,
		CLS_HIGH   = 2'd1,
		CLS_LOW    = 2'd2
	} tafs_cls_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
		tafs_cls_t               cls;
	} tafs_item_t;

	typedef logic signed [COS_W-1:0] cos_table_t [NUM_BOUNDS];

	// Boundary k is cos((2k+1)/2 deg) in Q1.COS_F, rounded half away from zero,
	// the upper half mirrored and negated.
	function automatic cos_table_t build_cos_table();
		cos_table_t t;
		real        x;
		real        v;
		int         r;
		for (int k = 0; k < NUM_BOUNDS / 2; k++) begin
			x = real'(2 * k + 1) * 3.14159265358979323846 / 360.0;
			v = $cos(x) * (2.0 ** COS_F);
			r = $rtoi(v + 0.5);
			t[k] = COS_W'(r);
			t[NUM_BOUNDS - 1 - k] = -COS_W'(r);
		end
		return t;
	endfunction

	localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

/* rtl/tafs_front.sv */
// Front end: forms squares, numerator and denominator, classifies the ratio.
module tafs_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [tafs_pkg::SIDE_W-1:0] side_a,
	input  logic [tafs_pkg::SIDE_W-1:0] side_b,
	input  logic [tafs_pkg::SIDE_W-1:0] side_c,
	input  logic                     q_full,
	output logic                     push,
	output tafs_pkg::tafs_item_t     push_item
);
	import tafs_pkg::*;

	logic [SQ_W-1:0] aa_s1, bb_s1, cc_s1, bc_s1;
	logic            v_s1;
	tafs_item_t      item_s2;
	logic            v_s2;
	logic            en;

	logic signed [NUM_W-1:0] num;
	logic [DEN_W-1:0]        den;
	tafs_cls_t               cls;

	assign en = !(v_s2 && q_full);
	assign item_stall = !en;

	always_comb begin
		num = $signed(NUM_W'(bb_s1) + NUM_W'(cc_s1)) - $signed(NUM_W'(aa_s1));
		den = {bc_s1, 1'b0};
		if (bc_s1 == '0 || num > $signed(NUM_W'(den)))
			cls = CLS_HIGH;
		else if (num < -$signed(NUM_W'(den)))
			cls = CLS_LOW;
		else
			cls = CLS_NORMAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s1 <= side_a * side_a;
			bb_s1 <= side_b * side_b;
			cc_s1 <= side_c * side_c;
			bc_s1 <= side_b * side_c;
			item_s2.num <= num;
			item_s2.den <= den;
			item_s2.cls <= cls;
		end
	end

	assign push      = en && v_s2;
	assign push_item = item_s2;
endmodule

/* rtl/tafs_queue.sv */
// Four-entry queue between front and back end.
module tafs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tafs_pkg::tafs_item_t push_item,
	input  logic                 pop,
	output tafs_pkg::tafs_item_t head,
	output logic                 full,
	output logic                 empty
);
	import tafs_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	tafs_item_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = cnt_q == (PTR_W+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(DEPTH))
		else $error("queue count out of range");
endmodule

/* rtl/tafs_back.sv */
// Back end: eight-step pipelined binary search over the cosine boundaries.
module tafs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  tafs_pkg::tafs_item_t       head,
	output logic                       pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [tafs_pkg::ANG_W-1:0] angle_degrees,
	output logic                       not_a_triangle
);
	import tafs_pkg::*;

	tafs_item_t       item_s [IDX_W];
	logic [IDX_W-1:0] lo_s   [IDX_W];
	logic             v_s    [IDX_W];
	logic             en;

	assign en  = !(v_s[IDX_W-1] && result_stall);
	assign pop = en && !q_empty;

	for (genvar i = 0; i < IDX_W; i++) begin : g_step
		tafs_item_t              in_item;
		logic [IDX_W-1:0]        in_lo;
		logic                    in_v;
		logic [IDX_W-1:0]        cand;
		logic [IDX_W-1:0]        idx;
		logic signed [COS_W-1:0] cb;
		logic signed [CMP_W-1:0] lhs, rhs;
		logic                    hit;

		if (i == 0) begin : g_first
			assign in_item = head;
			assign in_lo   = '0;
			assign in_v    = pop;
		end else begin : g_next
			assign in_item = item_s[i-1];
			assign in_lo   = lo_s[i-1];
			assign in_v    = v_s[i-1];
		end

		always_comb begin
			cand = in_lo | (IDX_W'(1) << (IDX_W - 1 - i));
			idx  = cand - 1'b1;
			cb   = (idx < IDX_W'(NUM_BOUNDS)) ? COS_TABLE[idx] : '0;
			lhs  = CMP_W'(in_item.num) <<< COS_F;
			rhs  = CMP_W'(cb) * $signed(CMP_W'({1'b0, in_item.den}));
			hit  = (idx < IDX_W'(NUM_BOUNDS)) && (lhs <= rhs);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= in_v;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[i] <= in_item;
				lo_s[i]   <= hit ? cand : in_lo;
			end
		end
	end

	always_comb begin
		unique case (item_s[IDX_W-1].cls)
			CLS_HIGH: angle_degrees = '0;
			CLS_LOW:  angle_degrees = ANGLE_MAX;
			default:  angle_degrees = lo_s[IDX_W-1];
		endcase
	end

	assign not_a_triangle = item_s[IDX_W-1].cls != CLS_NORMAL;
	assign result_valid   = v_s[IDX_W-1];
endmodule

/* rtl/triangle_angle_from_sides.sv */
// Path from input transfer to result: 2 front stages, the queue, 8 search stages.
// Throughput: one triangle per cycle when no stall is asserted; the search runs one table step per stage.
// Output stall with a valid result freezes the search pipe; the 4-entry queue keeps the front moving until full.
// Reset (arst_n low, asynchronous) empties the queue and clears all valid bits.
// Table is constant logic; no clearing pass is needed after reset.
module triangle_angle_from_sides (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [tafs_pkg::SIDE_W-1:0] side_a,
	input  logic [tafs_pkg::SIDE_W-1:0] side_b,
	input  logic [tafs_pkg::SIDE_W-1:0] side_c,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [tafs_pkg::ANG_W-1:0] angle_degrees,
	output logic                       not_a_triangle
);
	import tafs_pkg::*;

	tafs_item_t push_item, head;
	logic       push, pop, q_full, q_empty;

	// front: squares, num = b^2+c^2-a^2, den = 2bc, clamp class
	tafs_front u_front (
		.clk, .arst_n, .item_valid, .item_stall,
		.side_a, .side_b, .side_c,
		.q_full, .push, .push_item
	);

	tafs_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop,
		.head, .full(q_full), .empty(q_empty)
	);

	// back: counts boundaries with num*2^F <= C[k]*den, then applies clamps
	tafs_back u_back (
		.clk, .arst_n, .q_empty, .head, .pop,
		.result_valid, .result_stall, .angle_degrees, .not_a_triangle
	);
endmodule
